@@ rtl/sdsi_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsi_pkg
// Shared types and codes for the SPI-mode SD card init and sector read host.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsi_pkg;

  // Field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BrW     = 10;
  localparam int unsigned FrameW  = 48;
  localparam int unsigned CfgIdxW = 2;

  // Request kinds
  localparam logic [KindW-1:0] KIND_INIT  = 3'd0;
  localparam logic [KindW-1:0] KIND_BEGIN = 3'd1;
  localparam logic [KindW-1:0] KIND_READ  = 3'd2;
  localparam logic [KindW-1:0] KIND_END   = 3'd3;
  localparam logic [KindW-1:0] KIND_SPI   = 3'd4;

  // Completion status
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BUSY      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_READY = 2'd2;
  localparam logic [StatusW-1:0] STATUS_PAST_END  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDLE_CLOCKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd2;

  // Command indexes and framing constants
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_READ_SING = 6'd17;
  localparam logic [5:0] CMD_APP_OP    = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;

  localparam logic [ByteW-1:0] BYTE_IDLE     = 8'hFF;
  localparam logic [ByteW-1:0] BYTE_TOKEN    = 8'hFE;
  localparam logic [ByteW-1:0] BYTE_R1_IDLE  = 8'h01;
  localparam logic [ByteW-1:0] CRC_CMD0      = 8'h95;
  localparam logic [ByteW-1:0] CRC_CMD8      = 8'h87;
  localparam logic [AddrW-1:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [AddrW-1:0] ARG_HCS       = 32'h4000_0000;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] sector_address;
    logic [ByteW-1:0] rx_byte;
  } sdsi_in_t;

  typedef struct packed {
    logic               tx_valid;
    logic [ByteW-1:0]   tx_byte;
    logic               select_active;
    logic               data_valid;
    logic [ByteW-1:0]   data_byte;
    logic               done_res;
    logic [StatusW-1:0] status;
    logic               sector_finished;
  } sdsi_out_t;

  typedef struct packed {
    logic [ByteW-1:0] idle_clock_bytes;
    logic [ByteW-1:0] response_poll_limit;
    logic [ByteW-1:0] init_retry_limit;
  } sdsi_cfg_t;

  typedef struct packed {
    logic [3:0]        phase;
    logic [2:0]        frame_index;
    logic [FrameW-1:0] command_frame;
    logic [ByteW-1:0]  poll_count;
    logic [ByteW-1:0]  retry_count;
    logic [BrW-1:0]    bytes_remaining;
    logic              select_low;
  } sdsi_state_t;

endpackage : sdsi_pkg

`default_nettype wire

@@ rtl/sdsi_step.sv @@
// ----------------------------------------------------------------------------
// sdsi_step
// Next-state and result logic of the sequencer for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsi_step import sdsi_pkg::*; #(
  parameter int unsigned SectorBytes = 512
) (
  input  sdsi_state_t state_q_i,
  input  sdsi_in_t    item_i,
  input  sdsi_cfg_t   cfg_i,
  output sdsi_state_t state_d_o,
  output sdsi_out_t   result_o
);

  // Phase codes
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_CLOCKS = 4'd1;
  localparam logic [3:0] PH_SEND   = 4'd2;
  localparam logic [3:0] PH_POLL   = 4'd3;
  localparam logic [3:0] PH_TAIL   = 4'd4;
  localparam logic [3:0] PH_TOKEN  = 4'd5;
  localparam logic [3:0] PH_READ   = 4'd6;
  localparam logic [3:0] PH_DRAIN  = 4'd7;
  localparam logic [3:0] PH_CRC    = 4'd8;

  localparam logic [BrW-1:0] SectorInit = BrW'(SectorBytes);

  sdsi_state_t        s_d;
  sdsi_out_t          r;
  logic               cmd_go;
  logic [5:0]         cmd_idx;
  logic [AddrW-1:0]   cmd_arg;
  logic [ByteW-1:0]   cmd_crc;
  logic [2:0]         fi_inc;
  logic [ByteW-1:0]   poll_inc;
  logic [ByteW-1:0]   retry_inc;
  logic [BrW-1:0]     br_dec;
  logic [5:0]         resp_idx;
  logic [ByteW-1:0]   rx;

  assign fi_inc    = state_q_i.frame_index + 3'd1;
  assign poll_inc  = state_q_i.poll_count + 8'd1;
  assign retry_inc = state_q_i.retry_count + 8'd1;
  assign br_dec    = (state_q_i.bytes_remaining != '0) ?
                     state_q_i.bytes_remaining - BrW'(1) : state_q_i.bytes_remaining;
  assign resp_idx  = state_q_i.command_frame[45:40];
  assign rx        = item_i.rx_byte;

  always_comb begin
    s_d     = state_q_i;
    r       = '0;
    cmd_go  = 1'b0;
    cmd_idx = CMD_GO_IDLE;
    cmd_arg = '0;
    cmd_crc = BYTE_IDLE;

    if (item_i.kind <= KIND_END && state_q_i.phase != PH_IDLE) begin
      // Reject a request while a sequence runs
      r.done_res = 1'b1;
      r.status   = STATUS_BUSY;
    end else if (item_i.kind == KIND_INIT) begin
      s_d.phase       = PH_CLOCKS;
      s_d.poll_count  = '0;
      s_d.retry_count = '0;
      s_d.select_low  = 1'b0;
      r.tx_valid      = 1'b1;
      r.tx_byte       = BYTE_IDLE;
    end else if (item_i.kind == KIND_BEGIN) begin
      s_d.select_low      = 1'b1;
      s_d.bytes_remaining = '0;
      cmd_go  = 1'b1;
      cmd_idx = CMD_READ_SING;
      cmd_arg = item_i.sector_address;
    end else if (item_i.kind == KIND_READ) begin
      if (state_q_i.bytes_remaining == '0) begin
        s_d.phase  = PH_IDLE;
        r.done_res = 1'b1;
        r.status   = STATUS_PAST_END;
      end else begin
        s_d.phase  = PH_READ;
        r.tx_valid = 1'b1;
        r.tx_byte  = BYTE_IDLE;
      end
    end else if (item_i.kind == KIND_END) begin
      s_d.frame_index = '0;
      s_d.phase       = (state_q_i.bytes_remaining != '0) ? PH_DRAIN : PH_CRC;
      r.tx_valid      = 1'b1;
      r.tx_byte       = BYTE_IDLE;
    end else if (item_i.kind == KIND_SPI) begin
      // Advance on the returned byte
      unique case (state_q_i.phase)
        PH_IDLE: begin
        end
        PH_CLOCKS: begin
          s_d.poll_count = poll_inc;
          if (poll_inc == cfg_i.idle_clock_bytes) begin
            s_d.select_low = 1'b1;
            cmd_go  = 1'b1;
            cmd_idx = CMD_GO_IDLE;
            cmd_crc = CRC_CMD0;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_IDLE;
          end
        end
        PH_SEND: begin
          s_d.frame_index = fi_inc;
          r.tx_valid      = 1'b1;
          if (fi_inc >= 3'd6) begin
            s_d.phase      = PH_POLL;
            s_d.poll_count = '0;
            r.tx_byte      = BYTE_IDLE;
          end else begin
            unique case (fi_inc)
              3'd1:    r.tx_byte = state_q_i.command_frame[39:32];
              3'd2:    r.tx_byte = state_q_i.command_frame[31:24];
              3'd3:    r.tx_byte = state_q_i.command_frame[23:16];
              3'd4:    r.tx_byte = state_q_i.command_frame[15:8];
              3'd5:    r.tx_byte = state_q_i.command_frame[7:0];
              default: r.tx_byte = state_q_i.command_frame[47:40];
            endcase
          end
        end
        PH_POLL: begin
          s_d.poll_count = poll_inc;
          if (rx[7] && poll_inc != cfg_i.response_poll_limit) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_IDLE;
          end else begin
            // Act on the response of the command just sent
            unique case (resp_idx)
              CMD_GO_IDLE: begin
                cmd_go = 1'b1;
                if (rx == BYTE_R1_IDLE) begin
                  cmd_idx = CMD_IF_COND;
                  cmd_arg = ARG_IF_COND;
                  cmd_crc = CRC_CMD8;
                end else begin
                  cmd_idx = CMD_GO_IDLE;
                  cmd_crc = CRC_CMD0;
                end
              end
              CMD_IF_COND: begin
                s_d.phase       = PH_TAIL;
                s_d.frame_index = '0;
                r.tx_valid      = 1'b1;
                r.tx_byte       = BYTE_IDLE;
              end
              CMD_APP: begin
                cmd_go  = 1'b1;
                cmd_idx = CMD_APP_OP;
                cmd_arg = ARG_HCS;
              end
              CMD_APP_OP: begin
                s_d.retry_count = retry_inc;
                if (rx == '0 || retry_inc == cfg_i.init_retry_limit) begin
                  s_d.select_low      = 1'b0;
                  s_d.bytes_remaining = '0;
                  s_d.phase           = PH_IDLE;
                  r.done_res          = 1'b1;
                  r.status            = (rx == '0) ? STATUS_OK : STATUS_NOT_READY;
                end else begin
                  cmd_go  = 1'b1;
                  cmd_idx = CMD_APP;
                end
              end
              CMD_READ_SING: begin
                s_d.phase  = PH_TOKEN;
                r.tx_valid = 1'b1;
                r.tx_byte  = BYTE_IDLE;
              end
              default: s_d.phase = PH_IDLE;
            endcase
          end
        end
        PH_TAIL: begin
          s_d.frame_index = fi_inc;
          if (fi_inc >= 3'd4) begin
            s_d.retry_count = '0;
            cmd_go  = 1'b1;
            cmd_idx = CMD_APP;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_IDLE;
          end
        end
        PH_TOKEN: begin
          if (rx == BYTE_TOKEN) begin
            s_d.bytes_remaining = SectorInit;
            s_d.phase           = PH_IDLE;
            r.done_res          = 1'b1;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_IDLE;
          end
        end
        PH_READ: begin
          r.data_valid        = 1'b1;
          r.data_byte         = rx;
          s_d.bytes_remaining = br_dec;
          s_d.phase           = PH_IDLE;
          r.done_res          = 1'b1;
        end
        PH_DRAIN: begin
          s_d.bytes_remaining = br_dec;
          if (br_dec == '0) begin
            s_d.phase       = PH_CRC;
            s_d.frame_index = '0;
          end
          r.tx_valid = 1'b1;
          r.tx_byte  = BYTE_IDLE;
        end
        PH_CRC: begin
          s_d.frame_index = fi_inc;
          if (fi_inc >= 3'd2) begin
            s_d.select_low = 1'b0;
            s_d.phase      = PH_IDLE;
            r.done_res     = 1'b1;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_IDLE;
          end
        end
        default: s_d.phase = PH_IDLE;
      endcase
    end

    // Load a new command frame and send its first byte
    if (cmd_go) begin
      s_d.command_frame = {2'b01, cmd_idx, cmd_arg, cmd_crc};
      s_d.frame_index   = '0;
      s_d.poll_count    = '0;
      s_d.phase         = PH_SEND;
      r.tx_valid        = 1'b1;
      r.tx_byte         = {2'b01, cmd_idx};
    end

    r.select_active   = s_d.select_low;
    r.sector_finished = (s_d.bytes_remaining == '0);
  end

  assign state_d_o = s_d;
  assign result_o  = r;

endmodule : sdsi_step

`default_nettype wire

@@ rtl/sdsi_out_buf.sv @@
// ----------------------------------------------------------------------------
// sdsi_out_buf
// Two-word result buffer; its full flag is registered so the upstream stall
// never depends on the downstream stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsi_out_buf import sdsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sdsi_out_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sdsi_out_t out_data_o
);

  sdsi_out_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule : sdsi_out_buf

`default_nettype wire

@@ rtl/sd_spi_init_and_sector_read.sv @@
// ----------------------------------------------------------------------------
// sd_spi_init_and_sector_read
// SPI-mode SD card host sequencer: card init and single sector read.
// Datapath: a taken word is held in the input register; the step result is
// written into the result buffer, which offers it from its registers.
// Throughput: one word per cycle while the result buffer is not full, set by
// the single step of the sequencer between the input register and the
// two-word result buffer.
// Reset: sequencer idle, select high, no sector open, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_init_and_sector_read import sdsi_pkg::*; #(
  parameter int unsigned SectorBytes = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sdsi_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdsi_out_t          out_data_o
);

  sdsi_cfg_t   cfg_q;
  sdsi_state_t state_q, state_d;
  sdsi_in_t    item_q;
  logic        item_valid_q;
  logic        buf_full;
  logic        advance;
  logic        in_accept;
  sdsi_out_t   step_result;

  assign advance    = item_valid_q && !buf_full;
  assign in_stall_o = item_valid_q && buf_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_clock_bytes    <= 8'd10;
      cfg_q.response_poll_limit <= 8'd255;
      cfg_q.init_retry_limit    <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDLE_CLOCKS: cfg_q.idle_clock_bytes    <= cfg_data_i;
        CFG_POLL_LIMIT:  cfg_q.response_poll_limit <= cfg_data_i;
        CFG_RETRY_LIMIT: cfg_q.init_retry_limit    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted word until it is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
  end

  sdsi_step #(
    .SectorBytes(SectorBytes)
  ) u_step (
    .state_q_i (state_q),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .state_d_o (state_d),
    .result_o  (step_result)
  );

  // Update sequencer state once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  sdsi_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule : sd_spi_init_and_sector_read

`default_nettype wire

@@ tb/tb_sd_spi_init_and_sector_read.sv @@
// ----------------------------------------------------------------------------
// tb_sd_spi_init_and_sector_read
// Self-checking bench for the SPI-mode SD card init and sector read host.
// A card emulator builds request and reply words ahead of time from a planning
// copy of the sequencer. A second copy, stepped on every accepted word,
// predicts each result word, and the monitor compares it field by field.
// Both handshakes get random gaps and stalls, and there is one long hold-off
// on the result side. The run covers several register settings.
// ----------------------------------------------------------------------------

module tb_sd_spi_init_and_sector_read;
  timeunit 1ns;
  timeprecision 1ps;

  import sdsi_pkg::*;

  localparam int unsigned SectorBytes   = 512;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldOffCycles = 400;
  localparam logic [ByteW-1:0] R1_READY = 8'h00;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_CLOCKS, SEQ_SEND, SEQ_POLL, SEQ_TAIL,
    SEQ_TOKEN, SEQ_READ, SEQ_DRAIN, SEQ_CRC
  } seq_phase_e;

  typedef struct packed {
    logic [ByteW-1:0]  idle_clocks;
    logic [ByteW-1:0]  poll_limit;
    logic [ByteW-1:0]  retry_limit;
    seq_phase_e        phase;
    logic [3:0]        frame_index;
    logic [FrameW-1:0] command_frame;
    logic [ByteW-1:0]  poll_count;
    logic [ByteW-1:0]  retry_count;
    logic [BrW-1:0]    bytes_remaining;
    logic              select_low;
  } host_model_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  sdsi_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sdsi_out_t          out_data_o;

  sdsi_in_t    host_words_q[$];
  sdsi_out_t   expected_replies_q[$];
  host_model_t host_live;
  host_model_t host_plan;
  sdsi_out_t   expected_word;

  int words_counted = 0;
  int mismatches    = 0;
  int send_gap      = 0;
  int send_quiet    = 0;
  int stall_cnt     = 0;
  int recv_quiet    = 0;
  int hold_cnt      = 0;
  int idle_cycles   = 0;
  bit long_hold_req = 1'b0;

  // card behavior knobs, in percent
  int pct_busy, pct_cmd0_ok, pct_acmd_ok, pct_token;

  sd_spi_init_and_sector_read dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sequencer prediction
  // --------------------------------------------------------------------------
  function automatic host_model_t sequencer_at_reset();
    host_model_t m;
    m             = '0;
    m.idle_clocks = 8'd10;
    m.poll_limit  = 8'd255;
    m.retry_limit = 8'd255;
    m.phase       = SEQ_IDLE;
    return m;
  endfunction

  // Load a 6-byte command frame and put its first byte on the wire
  function automatic void load_command(inout host_model_t m, inout sdsi_out_t r,
                                       input logic [5:0] idx,
                                       input logic [AddrW-1:0] arg,
                                       input logic [ByteW-1:0] crc);
    m.command_frame = {2'b01, idx, arg, crc};
    m.frame_index   = '0;
    m.poll_count    = '0;
    m.phase         = SEQ_SEND;
    r.tx_valid      = 1'b1;
    r.tx_byte       = {2'b01, idx};
  endfunction

  function automatic sdsi_out_t step_sequencer(inout host_model_t m, input sdsi_in_t w);
    sdsi_out_t r;
    int        shift;
    r = '0;
    if (w.kind <= KIND_END && m.phase != SEQ_IDLE) begin
      // reject a request while a sequence runs, leave it untouched
      r.done_res = 1'b1;
      r.status   = STATUS_BUSY;
    end else begin
      case (w.kind)
        KIND_INIT: begin
          m.phase       = SEQ_CLOCKS;
          m.poll_count  = '0;
          m.retry_count = '0;
          m.select_low  = 1'b0;
          r.tx_valid    = 1'b1;
          r.tx_byte     = BYTE_IDLE;
        end
        KIND_BEGIN: begin
          m.select_low      = 1'b1;
          m.bytes_remaining = '0;
          load_command(m, r, CMD_READ_SING, w.sector_address, BYTE_IDLE);
        end
        KIND_READ: begin
          if (m.bytes_remaining == 0) begin
            m.phase    = SEQ_IDLE;
            r.done_res = 1'b1;
            r.status   = STATUS_PAST_END;
          end else begin
            m.phase    = SEQ_READ;
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_IDLE;
          end
        end
        KIND_END: begin
          m.frame_index = '0;
          m.phase       = (m.bytes_remaining != 0) ? SEQ_DRAIN : SEQ_CRC;
          r.tx_valid    = 1'b1;
          r.tx_byte     = BYTE_IDLE;
        end
        KIND_SPI: begin
          case (m.phase)
            SEQ_CLOCKS: begin
              m.poll_count = m.poll_count + 8'd1;
              if (m.poll_count == m.idle_clocks) begin
                m.select_low = 1'b1;
                load_command(m, r, CMD_GO_IDLE, '0, CRC_CMD0);
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = BYTE_IDLE;
              end
            end
            SEQ_SEND: begin
              m.frame_index = m.frame_index + 4'd1;
              r.tx_valid    = 1'b1;
              if (m.frame_index >= 6) begin
                m.phase      = SEQ_POLL;
                m.poll_count = '0;
                r.tx_byte    = BYTE_IDLE;
              end else begin
                shift     = 40 - 8 * int'(m.frame_index);
                r.tx_byte = 8'(m.command_frame >> shift);
              end
            end
            SEQ_POLL: begin
              m.poll_count = m.poll_count + 8'd1;
              if (w.rx_byte[7] && m.poll_count != m.poll_limit) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = BYTE_IDLE;
              end else begin
                // act on the response to the command just sent
                case (m.command_frame[45:40])
                  CMD_GO_IDLE: begin
                    if (w.rx_byte == BYTE_R1_IDLE)
                      load_command(m, r, CMD_IF_COND, ARG_IF_COND, CRC_CMD8);
                    else
                      load_command(m, r, CMD_GO_IDLE, '0, CRC_CMD0);
                  end
                  CMD_IF_COND: begin
                    m.phase       = SEQ_TAIL;
                    m.frame_index = '0;
                    r.tx_valid    = 1'b1;
                    r.tx_byte     = BYTE_IDLE;
                  end
                  CMD_APP: load_command(m, r, CMD_APP_OP, ARG_HCS, BYTE_IDLE);
                  CMD_APP_OP: begin
                    m.retry_count = m.retry_count + 8'd1;
                    if (w.rx_byte == R1_READY || m.retry_count == m.retry_limit) begin
                      m.select_low      = 1'b0;
                      m.bytes_remaining = '0;
                      m.phase           = SEQ_IDLE;
                      r.done_res        = 1'b1;
                      r.status = (w.rx_byte == R1_READY) ? STATUS_OK : STATUS_NOT_READY;
                    end else begin
                      load_command(m, r, CMD_APP, '0, BYTE_IDLE);
                    end
                  end
                  CMD_READ_SING: begin
                    m.phase    = SEQ_TOKEN;
                    r.tx_valid = 1'b1;
                    r.tx_byte  = BYTE_IDLE;
                  end
                  default: m.phase = SEQ_IDLE;
                endcase
              end
            end
            SEQ_TAIL: begin
              m.frame_index = m.frame_index + 4'd1;
              if (m.frame_index >= 4) begin
                m.retry_count = '0;
                load_command(m, r, CMD_APP, '0, BYTE_IDLE);
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = BYTE_IDLE;
              end
            end
            SEQ_TOKEN: begin
              if (w.rx_byte == BYTE_TOKEN) begin
                m.bytes_remaining = BrW'(SectorBytes);
                m.phase           = SEQ_IDLE;
                r.done_res        = 1'b1;
                r.status          = STATUS_OK;
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = BYTE_IDLE;
              end
            end
            SEQ_READ: begin
              r.data_valid = 1'b1;
              r.data_byte  = w.rx_byte;
              if (m.bytes_remaining != 0) m.bytes_remaining = m.bytes_remaining - 1'b1;
              m.phase    = SEQ_IDLE;
              r.done_res = 1'b1;
              r.status   = STATUS_OK;
            end
            SEQ_DRAIN: begin
              if (m.bytes_remaining != 0) m.bytes_remaining = m.bytes_remaining - 1'b1;
              if (m.bytes_remaining == 0) begin
                m.phase       = SEQ_CRC;
                m.frame_index = '0;
              end
              r.tx_valid = 1'b1;
              r.tx_byte  = BYTE_IDLE;
            end
            SEQ_CRC: begin
              m.frame_index = m.frame_index + 4'd1;
              if (m.frame_index >= 2) begin
                m.select_low = 1'b0;
                m.phase      = SEQ_IDLE;
                r.done_res   = 1'b1;
                r.status     = STATUS_OK;
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = BYTE_IDLE;
              end
            end
            default: m.phase = SEQ_IDLE;
          endcase
        end
        default: ;
      endcase
    end
    r.select_active   = m.select_low;
    r.sector_finished = (m.bytes_remaining == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void plan_word(input logic [KindW-1:0] kind,
                                    input logic [AddrW-1:0] addr,
                                    input logic [ByteW-1:0] rx);
    sdsi_in_t w;
    w.kind           = kind;
    w.sector_address = addr;
    w.rx_byte        = rx;
    // words the block just ignores do not count
    if (kind < KIND_SPI || (kind == KIND_SPI && host_plan.phase != SEQ_IDLE))
      words_counted++;
    void'(step_sequencer(host_plan, w));
    host_words_q.push_back(w);
  endfunction

  // Answer the host as a card would, given what it waits for
  function automatic logic [ByteW-1:0] card_reply();
    logic [ByteW-1:0] b;
    int               r;
    r = $urandom_range(0, 99);
    b = ByteW'($urandom_range(0, 255));
    case (host_plan.phase)
      SEQ_POLL: begin
        if (r < pct_busy) begin
          b[7] = 1'b1;
        end else begin
          b[7] = 1'b0;
          case (host_plan.command_frame[45:40])
            CMD_GO_IDLE: if ($urandom_range(0, 99) < pct_cmd0_ok) b = BYTE_R1_IDLE;
            CMD_APP_OP:  if ($urandom_range(0, 99) < pct_acmd_ok) b = R1_READY;
            default: ;
          endcase
        end
      end
      SEQ_TOKEN: begin
        if (r < pct_token) b = BYTE_TOKEN;
        else if (r < pct_token + 40) b = BYTE_IDLE;
      end
      default: ;
    endcase
    return b;
  endfunction

  // Feed card bytes until the running request completes; mix in noise
  function automatic void finish_request();
    int r;
    while (host_plan.phase != SEQ_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        plan_word(KindW'($urandom_range(int'(KIND_INIT), int'(KIND_END))),
                  $urandom, ByteW'($urandom));
      else if (r < 5)
        plan_word(KIND_SPI + KindW'($urandom_range(1, 3)), $urandom, ByteW'($urandom));
      else
        plan_word(KIND_SPI, $urandom, card_reply());
    end
  endfunction

  function automatic void random_transaction();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      plan_word(KIND_INIT, $urandom, ByteW'($urandom));
      finish_request();
    end else if (r < 50) begin
      plan_word(KIND_BEGIN, $urandom, ByteW'($urandom));
      finish_request();
      n = $urandom_range(0, 6);
      repeat (n) begin
        plan_word(KIND_READ, $urandom, ByteW'($urandom));
        finish_request();
      end
    end else if (r < 60) begin
      // draining an open sector is long, do it rarely
      if (host_plan.bytes_remaining == 0 || $urandom_range(0, 7) == 0) begin
        plan_word(KIND_END, $urandom, ByteW'($urandom));
        finish_request();
      end
    end else if (r < 80) begin
      plan_word(KIND_READ, $urandom, ByteW'($urandom));
      finish_request();
    end else begin
      plan_word(KIND_SPI + KindW'($urandom_range(0, 3)), $urandom, ByteW'($urandom));
    end
  endfunction

  function automatic void run_random(input int count);
    int start;
    start = words_counted;
    while (words_counted - start < count) random_transaction();
  endfunction

  // Wait until every planned word is taken and every result has come back
  task automatic settle();
    while (host_words_q.size() != 0 || in_valid_i || expected_replies_q.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IDLE_CLOCKS: begin
        host_live.idle_clocks = val;
        host_plan.idle_clocks = val;
      end
      CFG_POLL_LIMIT: begin
        host_live.poll_limit = val;
        host_plan.poll_limit = val;
      end
      CFG_RETRY_LIMIT: begin
        host_live.retry_limit = val;
        host_plan.retry_limit = val;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer planned words, step the predictor on each accepted one
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) expected_replies_q.push_back(step_sequencer(host_live, in_data_i));
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (host_words_q.size() > 0) begin
          in_data_i  <= host_words_q.pop_front();
          in_valid_i <= 1'b1;
          if (send_quiet > 0) begin
            send_quiet--;
          end else begin
            send_gap = pick_gap();
            if ($urandom_range(0, 99) == 0) send_quiet = $urandom_range(30, 100);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result word with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none actual %h", $time, out_data_o);
        end else begin
          expected_word = expected_replies_q.pop_front();
          report("tx_valid", expected_word.tx_valid, out_data_o.tx_valid);
          report("tx_byte", expected_word.tx_byte, out_data_o.tx_byte);
          report("select_active", expected_word.select_active, out_data_o.select_active);
          report("data_valid", expected_word.data_valid, out_data_o.data_valid);
          report("data_byte", expected_word.data_byte, out_data_o.data_byte);
          report("done_res", expected_word.done_res, out_data_o.done_res);
          report("status", expected_word.status, out_data_o.status);
          report("sector_finished", expected_word.sector_finished,
                 out_data_o.sector_finished);
        end
      end
      // stall the result side: a long hold-off on request, else random
      if (long_hold_req) begin
        hold_cnt      = HoldOffCycles;
        long_hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (recv_quiet > 0) begin
          recv_quiet--;
        end else begin
          stall_cnt = pick_gap();
          if ($urandom_range(0, 99) == 0) recv_quiet = $urandom_range(30, 100);
        end
      end
    end
  end

  // Watchdog: count cycles with work pending but no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else if (host_words_q.size() != 0 || in_valid_i || expected_replies_q.size() != 0)
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("tb_sd_spi_init_and_sector_read failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      <= 1'b0;
    host_live   = sequencer_at_reset();
    host_plan   = sequencer_at_reset();
    pct_busy    = 25;
    pct_cmd0_ok = 70;
    pct_acmd_ok = 0;
    pct_token   = 35;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lowest limits: one clock byte, one poll, one attempt
    write_reg(CFG_IDLE_CLOCKS, 8'd1);
    write_reg(CFG_POLL_LIMIT, 8'd1);
    write_reg(CFG_RETRY_LIMIT, 8'd1);

    // spurious card bytes and unused kinds while idle
    plan_word(KIND_SPI, '1, '1);
    for (int k = int'(KIND_SPI) + 1; k < 8; k++) plan_word(KindW'(k), '0, '0);
    // read with no open sector, end with no open sector
    plan_word(KIND_READ, '0, '0);
    plan_word(KIND_END, '0, '0);
    finish_request();
    // begin at the top address, every request kind rejected while busy
    plan_word(KIND_BEGIN, '1, '0);
    plan_word(KIND_INIT, '0, '0);
    plan_word(KIND_READ, '0, '0);
    plan_word(KIND_END, '0, '0);
    plan_word(KIND_BEGIN, '0, '0);
    repeat (6) plan_word(KIND_SPI, '0, ByteW'($urandom));
    // busy response hits the poll limit, then wait out the token
    plan_word(KIND_SPI, '0, BYTE_IDLE);
    plan_word(KIND_SPI, '0, BYTE_IDLE);
    plan_word(KIND_SPI, '0, '0);
    plan_word(KIND_SPI, '0, BYTE_TOKEN);
    plan_word(KIND_READ, '0, '0);
    plan_word(KIND_SPI, '0, '0);
    plan_word(KIND_READ, '0, '0);
    plan_word(KIND_SPI, '0, '1);
    // begin over an open sector drops it
    plan_word(KIND_BEGIN, '0, '0);
    finish_request();

    // card never ready: init gives up after one attempt
    plan_word(KIND_INIT, $urandom, ByteW'($urandom));
    finish_request();
    run_random(40);
    settle();

    // reset values, a card that comes up, one full sector drain
    write_reg(CFG_IDLE_CLOCKS, 8'd10);
    write_reg(CFG_POLL_LIMIT, 8'd255);
    write_reg(CFG_RETRY_LIMIT, 8'd255);
    pct_acmd_ok = 40;
    plan_word(KIND_INIT, $urandom, ByteW'($urandom));
    finish_request();
    plan_word(KIND_BEGIN, $urandom, ByteW'($urandom));
    finish_request();
    repeat (3) begin
      plan_word(KIND_READ, $urandom, ByteW'($urandom));
      finish_request();
    end
    plan_word(KIND_END, $urandom, ByteW'($urandom));
    finish_request();
    run_random(40);
    long_hold_req = 1'b1;
    settle();

    // zero registers count as 256
    write_reg(CFG_IDLE_CLOCKS, 8'd0);
    write_reg(CFG_POLL_LIMIT, 8'd0);
    write_reg(CFG_RETRY_LIMIT, 8'd0);
    pct_acmd_ok = 50;
    plan_word(KIND_INIT, $urandom, ByteW'($urandom));
    finish_request();
    run_random(20);
    settle();

    // random small limits with a sluggish card
    write_reg(CFG_IDLE_CLOCKS, ByteW'($urandom_range(1, 30)));
    write_reg(CFG_POLL_LIMIT, ByteW'($urandom_range(2, 6)));
    write_reg(CFG_RETRY_LIMIT, ByteW'($urandom_range(2, 5)));
    pct_busy    = 50;
    pct_acmd_ok = 20;
    run_random(60);
    settle();

    if (mismatches == 0) begin
      $display("tb_sd_spi_init_and_sector_read passed");
    end else begin
      $display("tb_sd_spi_init_and_sector_read failed");
    end
    $finish;
  end

endmodule
